FILE: rtl/sexpr_tokenizer_macros.svh
// Assertion macros used by the tokenizer's checker file.
`ifndef SEXPR_TOKENIZER_MACROS_SVH
`define SEXPR_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SXT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SXT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sxt_pkg.sv
// Shared types and constants for the s-expression tokenizer.
package sxt_pkg;

    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POSITION_MAX = 16'hFFFF;

    // Result queue geometry
    localparam int TQ_DEPTH = 4;
    localparam int TQ_AW    = $clog2(TQ_DEPTH);
    localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_LPAREN   = 4'd0,
        KIND_RPAREN   = 4'd1,
        KIND_INT      = 4'd2,
        KIND_STRING   = 4'd3,
        KIND_DOT      = 4'd4,
        KIND_FLOAT    = 4'd5,
        KIND_NIL      = 4'd6,
        KIND_TRUE     = 4'd7,
        KIND_QUOTE    = 4'd8,
        KIND_SYMBOL   = 4'd9,
        KIND_UNCLOSED = 4'd10,
        KIND_EOI      = 4'd11
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] start_line;
        logic [POS_W-1:0] start_column;
        logic [POS_W-1:0] length;
        logic             last;
    } t_tok;

    // Up to two tokens pushed into the result queue per character
    typedef struct packed {
        logic p0_valid;
        logic p1_valid;
        t_tok tok0;
        t_tok tok1;
    } t_push;

endpackage

FILE: rtl/sxt_if.sv
// Valid/ready channel interfaces for characters in and tokens out.
interface sxt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, char_code, end_of_input, input ready);
    modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

interface sxt_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] length;
    logic        last;

    modport source (output valid, kind, start_line, start_column, length, last, input ready);
    modport sink   (input valid, kind, start_line, start_column, length, last, output ready);
endinterface

FILE: rtl/sxt_lexer.sv
// Input register and single-pass lexer state update producing up to two tokens.
module sxt_lexer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sxt_char_if.sink       i_char,
    input  logic           i_room,
    output sxt_pkg::t_push o_push
);

    typedef enum logic [5:0] {
        M_IDLE         = 6'b000001,
        M_COMMENT      = 6'b000010,
        M_OPEN         = 6'b000100,
        M_OPEN_COMMENT = 6'b001000,
        M_STRING       = 6'b010000,
        M_ATOM         = 6'b100000
    } t_mode;

    typedef enum logic [9:0] {
        K_START = 10'b0000000001,
        K_DEAD  = 10'b0000000010,
        K_DOT   = 10'b0000000100,
        K_T     = 10'b0000001000,
        K_HASH  = 10'b0000010000,
        K_HASHT = 10'b0000100000,
        K_HASHF = 10'b0001000000,
        K_N     = 10'b0010000000,
        K_NI    = 10'b0100000000,
        K_NIL   = 10'b1000000000
    } t_kw;

    typedef enum logic [7:0] {
        N_START = 8'b00000001,
        N_DEAD  = 8'b00000010,
        N_SIGN  = 8'b00000100,
        N_INT   = 8'b00001000,
        N_DOT0  = 8'b00010000,
        N_SDOT  = 8'b00100000,
        N_FRAC  = 8'b01000000,
        N_FEND  = 8'b10000000
    } t_num;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam int PW = sxt_pkg::POS_W;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (v == sxt_pkg::POSITION_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_NUL;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return is_blank(c) || c == CH_LP || c == CH_RP || c == CH_DQ || c == CH_SQ
            || c == CH_SEMI;
    endfunction

    function automatic t_kw kw_next(input t_kw s, input logic [7:0] c);
        t_kw k;
        k = K_DEAD;
        case (s)
            K_START: begin
                if (c == CH_DOT)       k = K_DOT;
                else if (c == CH_T)    k = K_T;
                else if (c == CH_HASH) k = K_HASH;
                else if (c == CH_N)    k = K_N;
            end
            K_HASH: begin
                if (c == CH_T)      k = K_HASHT;
                else if (c == CH_F) k = K_HASHF;
            end
            K_N:     if (c == CH_I) k = K_NI;
            K_NI:    if (c == CH_L) k = K_NIL;
            default: k = K_DEAD;
        endcase
        return k;
    endfunction

    function automatic t_num num_next(input t_num s, input logic [7:0] c);
        t_num n;
        logic d;
        d = (c >= CH_D0) && (c <= CH_D9);
        n = N_DEAD;
        case (s)
            N_START: begin
                if (c == CH_PLUS || c == CH_MINUS) n = N_SIGN;
                else if (d)                         n = N_INT;
                else if (c == CH_DOT)               n = N_DOT0;
            end
            N_SIGN: begin
                if (d)                n = N_INT;
                else if (c == CH_DOT) n = N_SDOT;
            end
            N_INT: begin
                if (d)                n = N_INT;
                else if (c == CH_DOT) n = N_FRAC;
            end
            N_DOT0, N_SDOT, N_FRAC: begin
                if (d)              n = N_FRAC;
                else if (c == CH_F) n = N_FEND;
            end
            default: n = N_DEAD;
        endcase
        return n;
    endfunction

    function automatic sxt_pkg::t_kind atom_kind(input t_kw k, input t_num n);
        sxt_pkg::t_kind r;
        if (k == K_DOT)                       r = sxt_pkg::KIND_DOT;
        else if (k == K_T || k == K_HASHT)    r = sxt_pkg::KIND_TRUE;
        else if (k == K_HASHF || k == K_NIL)  r = sxt_pkg::KIND_NIL;
        else if (n == N_INT)                  r = sxt_pkg::KIND_INT;
        else if (n == N_FRAC || n == N_FEND)  r = sxt_pkg::KIND_FLOAT;
        else                                  r = sxt_pkg::KIND_SYMBOL;
        return r;
    endfunction

    function automatic sxt_pkg::t_tok mk_tok(input sxt_pkg::t_kind k,
                                             input logic [PW-1:0] ln,
                                             input logic [PW-1:0] col,
                                             input logic [PW-1:0] len);
        sxt_pkg::t_tok t;
        t.kind         = k;
        t.start_line   = ln;
        t.start_column = col;
        t.length       = len;
        t.last         = 1'b0;
        return t;
    endfunction

    // Input register
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_eoi;

    // Scanner state
    t_mode         r_mode, n_mode;
    logic          r_bsl, n_bsl;
    logic [PW-1:0] r_line, n_line;
    logic [PW-1:0] r_col, n_col;
    logic [PW-1:0] r_tline, n_tline;
    logic [PW-1:0] r_tcol, n_tcol;
    logic [PW-1:0] r_tlen, n_tlen;
    t_kw           r_kw, n_kw;
    t_num          r_num, n_num;

    logic          fire;
    logic          start;
    logic [PW-1:0] cc;
    logic          a_v, b_v;
    sxt_pkg::t_tok a_tok, b_tok;

    assign fire         = r_valid && i_room;
    assign i_char.ready = !r_valid || fire;
    assign cc           = sat_inc(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_char <= i_char.char_code;
            r_eoi  <= i_char.end_of_input;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_bsl   = r_bsl;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        n_tlen  = r_tlen;
        n_kw    = r_kw;
        n_num   = r_num;
        start   = 1'b0;
        a_v     = 1'b0;
        b_v     = 1'b0;
        a_tok   = '0;
        b_tok   = '0;

        if (fire) begin
            if (r_eoi) begin
                // Flush a pending atom or open paren, report the end, return to reset state
                if (r_mode == M_ATOM) begin
                    a_v   = 1'b1;
                    a_tok = mk_tok(atom_kind(r_kw, r_num), r_tline, r_tcol, r_tlen);
                end else if (r_mode == M_OPEN || r_mode == M_OPEN_COMMENT) begin
                    a_v   = 1'b1;
                    a_tok = mk_tok(sxt_pkg::KIND_LPAREN, r_tline, r_tcol, PW'(1));
                end
                b_v     = 1'b1;
                b_tok   = mk_tok(sxt_pkg::KIND_EOI, r_line, cc, '0);
                n_mode  = M_IDLE;
                n_bsl   = 1'b0;
                n_line  = PW'(1);
                n_col   = '0;
                n_tline = PW'(1);
                n_tcol  = PW'(1);
                n_tlen  = '0;
                n_kw    = K_START;
                n_num   = N_START;
            end else begin
                case (r_mode)
                    M_COMMENT: begin
                        if (r_char == CH_LF) n_mode = M_IDLE;
                    end
                    M_OPEN_COMMENT: begin
                        if (r_char == CH_LF) n_mode = M_OPEN;
                    end
                    M_OPEN: begin
                        if (is_blank(r_char)) begin
                            n_mode = M_OPEN;
                        end else if (r_char == CH_SEMI) begin
                            n_mode = M_OPEN_COMMENT;
                        end else if (r_char == CH_RP) begin
                            a_v    = 1'b1;
                            a_tok  = mk_tok(sxt_pkg::KIND_NIL, r_tline, r_tcol, PW'(2));
                            n_mode = M_IDLE;
                        end else begin
                            a_v   = 1'b1;
                            a_tok = mk_tok(sxt_pkg::KIND_LPAREN, r_tline, r_tcol, PW'(1));
                            start = 1'b1;
                        end
                    end
                    M_STRING: begin
                        if (r_char == CH_LF) begin
                            a_v    = 1'b1;
                            a_tok  = mk_tok(sxt_pkg::KIND_UNCLOSED, r_tline, r_tcol, r_tlen);
                            n_mode = M_IDLE;
                            n_bsl  = 1'b0;
                        end else if (r_char == CH_DQ && !r_bsl) begin
                            n_tlen = sat_inc(r_tlen);
                            a_v    = 1'b1;
                            a_tok  = mk_tok(sxt_pkg::KIND_STRING, r_tline, r_tcol, n_tlen);
                            n_mode = M_IDLE;
                        end else begin
                            n_tlen = sat_inc(r_tlen);
                            n_bsl  = (r_char == CH_BSL);
                        end
                    end
                    M_ATOM: begin
                        if (is_sep(r_char)) begin
                            a_v   = 1'b1;
                            a_tok = mk_tok(atom_kind(r_kw, r_num), r_tline, r_tcol, r_tlen);
                            start = 1'b1;
                        end else begin
                            n_tlen = sat_inc(r_tlen);
                            n_kw   = kw_next(r_kw, r_char);
                            n_num  = num_next(r_num, r_char);
                        end
                    end
                    default: start = 1'b1;
                endcase

                // Begin a new token from this character
                if (start) begin
                    n_mode = M_IDLE;
                    if (is_blank(r_char)) begin
                        n_mode = M_IDLE;
                    end else if (r_char == CH_SEMI) begin
                        n_mode = M_COMMENT;
                    end else if (r_char == CH_RP) begin
                        b_v   = 1'b1;
                        b_tok = mk_tok(sxt_pkg::KIND_RPAREN, r_line, cc, PW'(1));
                    end else if (r_char == CH_SQ) begin
                        b_v   = 1'b1;
                        b_tok = mk_tok(sxt_pkg::KIND_QUOTE, r_line, cc, PW'(1));
                    end else begin
                        n_tline = r_line;
                        n_tcol  = cc;
                        n_tlen  = PW'(1);
                        if (r_char == CH_LP) begin
                            n_mode = M_OPEN;
                        end else if (r_char == CH_DQ) begin
                            n_mode = M_STRING;
                            n_bsl  = 1'b0;
                        end else begin
                            n_mode = M_ATOM;
                            n_kw   = kw_next(K_START, r_char);
                            n_num  = num_next(N_START, r_char);
                        end
                    end
                end

                if (r_char == CH_LF) begin
                    n_line = sat_inc(r_line);
                    n_col  = '0;
                end else begin
                    n_col = cc;
                end
            end
        end
    end

    // Pack the flushed token ahead of the newly started one
    always_comb begin
        o_push.p0_valid  = a_v || b_v;
        o_push.p1_valid  = a_v && b_v;
        o_push.tok0      = a_v ? a_tok : b_tok;
        o_push.tok0.last = !(a_v && b_v);
        o_push.tok1      = b_tok;
        o_push.tok1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_bsl   <= 1'b0;
            r_line  <= PW'(1);
            r_col   <= '0;
            r_tline <= PW'(1);
            r_tcol  <= PW'(1);
            r_tlen  <= '0;
            r_kw    <= K_START;
            r_num   <= N_START;
        end else begin
            r_mode  <= n_mode;
            r_bsl   <= n_bsl;
            r_line  <= n_line;
            r_col   <= n_col;
            r_tline <= n_tline;
            r_tcol  <= n_tcol;
            r_tlen  <= n_tlen;
            r_kw    <= n_kw;
            r_num   <= n_num;
        end
    end

endmodule

FILE: rtl/sxt_tok_fifo.sv
// Result queue: takes up to two tokens per cycle, hands out one per transaction.
module sxt_tok_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sxt_pkg::t_push i_push,
    output logic           o_room,
    sxt_tok_if.source      o_tok
);

    localparam int AW = sxt_pkg::TQ_AW;
    localparam int CW = sxt_pkg::TQ_CW;

    sxt_pkg::t_tok r_mem [sxt_pkg::TQ_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    push_n;
    logic          pop;
    sxt_pkg::t_tok head;

    assign head   = r_mem[r_rd];
    assign pop    = o_tok.valid && o_tok.ready;
    assign push_n = {1'b0, i_push.p0_valid} + {1'b0, i_push.p1_valid};
    // Room for a full pair regardless of this cycle's pop
    assign o_room = r_count <= CW'(sxt_pkg::TQ_DEPTH - 2);

    assign o_tok.valid        = r_count != '0;
    assign o_tok.kind         = head.kind;
    assign o_tok.start_line   = head.start_line;
    assign o_tok.start_column = head.start_column;
    assign o_tok.length       = head.length;
    assign o_tok.last         = head.last;

    always_comb begin
        n_wr    = r_wr + AW'(push_n);
        n_rd    = r_rd + AW'(pop);
        n_count = r_count + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.p0_valid) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.p1_valid) begin
            r_mem[r_wr + AW'(1)] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/sexpr_tokenizer.sv
// The character that ends a token is held in the input register, and the token it
//   yields is written into the result queue once there is room; o_tok presents it.
// Throughput: one character per cycle; the input stalls while the four-entry result
//   queue holds more than two tokens, and one character can yield two tokens.
// Reset (i_rst_n low, synchronous): scanner idle at line 1, column 0, queue empty.
module sexpr_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sxt_char_if.sink  i_char,
    sxt_tok_if.source o_tok
);

    sxt_pkg::t_push push;
    logic           room;

    sxt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_room  (room),
        .o_push  (push)
    );

    sxt_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_tok   (o_tok)
    );

endmodule

FILE: rtl/sxt_checker.sv
// Port-level checker for the tokenizer's output channel, bound to the top level.
`include "sexpr_tokenizer_macros.svh"

module sxt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [3:0]  i_kind,
    input logic [15:0] i_line,
    input logic [15:0] i_column,
    input logic [15:0] i_length,
    input logic        i_last
);

    `SXT_ASSERT_NEXT(a_hold, i_valid && !i_ready, i_valid && $stable(i_kind) && $stable(i_line) && $stable(i_column) && $stable(i_length) && $stable(i_last), "stalled token changed")
    `SXT_ASSERT_IMPL(a_eoi_last, i_valid && i_kind == sxt_pkg::KIND_EOI, i_last && i_length == 16'd0, "end token not last or not empty")
    `SXT_ASSERT_IMPL(a_single, i_valid && (i_kind == sxt_pkg::KIND_LPAREN || i_kind == sxt_pkg::KIND_RPAREN || i_kind == sxt_pkg::KIND_QUOTE), i_length == 16'd1, "punctuation length not one")
    `SXT_ASSERT_IMPL(a_pos, i_valid, i_line != 16'd0 && i_column != 16'd0, "token position not one-based")

endmodule

bind sexpr_tokenizer sxt_checker u_sxt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_tok.valid),
    .i_ready  (o_tok.ready),
    .i_kind   (o_tok.kind),
    .i_line   (o_tok.start_line),
    .i_column (o_tok.start_column),
    .i_length (o_tok.length),
    .i_last   (o_tok.last)
);
